/* rtl/slab_bitmap_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Slab bitmap allocator assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef SLAB_BITMAP_ALLOCATOR_MACROS_SVH
`define SLAB_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sba_pkg.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator package
// Sizes, codes, state encoding and control bundles shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sba_pkg;

	localparam int CHUNK_BYTES = 4096;
	localparam int MAX_CHUNKS  = 16;
	localparam int MAX_OBJECTS = 64;

	localparam int A_W       = 32;
	localparam int Q_W       = 13;
	localparam int CNT_W     = 7;
	localparam int CB_W      = $clog2(CHUNK_BYTES);
	localparam int QMIN      = (CHUNK_BYTES + MAX_OBJECTS - 1) / MAX_OBJECTS;
	localparam int DVD_W     = CB_W + 1;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);
	localparam int NOBJ_W    = $clog2(MAX_OBJECTS + 1);
	localparam int IDX_W     = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int K_W       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int OPN_W     = $clog2(MAX_CHUNKS + 1);
	localparam int CHK_W     = CB_W + 2;
	localparam int PROD_W    = IDX_W + Q_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_OOM    = 2'd1,
		ST_BAD    = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic {
		REG_QUANTUM = 1'b0,
		REG_BASE    = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ARD,
		S_ACHK,
		S_OPEN,
		S_FRD,
		S_FCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    alloc_init;
		logic    free_init;
		logic    rd;
		logic    dec_k;
		logic    alloc_take;
		logic    open;
		logic    free_commit;
		logic    mul;
		logic    set_st;
		status_t st;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic kind;
		logic opened_zero;
		logic k_zero;
		logic hit;
		logic full;
		logic free_bad;
		logic bit_set;
		logic out_free;
	} sts_t;

endpackage

/* rtl/sba_div.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sba_div
	import sba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [Q_W-1:0]   divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [Q_W-1:0]   remainder
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     quo_q;
	logic [Q_W-1:0]       rem_q;
	logic [Q_W-1:0]       dsr_q;
	logic [Q_W:0]         rem_sh;
	logic                 ge;
	logic [Q_W:0]         rem_sub;

	assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DVD_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[Q_W-1:0] : rem_sh[Q_W-1:0];
		end
	end

	assign done      = busy_q && cnt_q == '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/sba_ctrl.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator controller
// Sequences one request through divide, chunk scan or bitmap lookup, update and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sba_ctrl
	import sba_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					if (sts.kind == KIND_ALLOC) begin
						state_d = sts.opened_zero ? S_OPEN : S_ARD;
					end else begin
						state_d = sts.free_bad ? S_DONE : S_FRD;
					end
				end
			end
			S_ARD: state_d = S_ACHK;
			S_ACHK: begin
				priority if (sts.hit) state_d = S_DONE;
				else if (sts.k_zero) state_d = S_OPEN;
				else state_d = S_ARD;
			end
			S_OPEN: state_d = S_DONE;
			S_FRD:  state_d = S_FCHK;
			S_FCHK: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.st   = ST_OK;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DIV: begin
				if (sts.div_done) begin
					if (sts.kind == KIND_ALLOC) begin
						cmd.alloc_init = 1'b1;
					end else begin
						cmd.free_init = 1'b1;
						cmd.set_st    = sts.free_bad;
						cmd.st        = ST_BAD;
					end
				end
			end
			S_ARD: cmd.rd = 1'b1;
			S_ACHK: begin
				cmd.alloc_take = sts.hit;
				cmd.mul        = sts.hit;
				cmd.dec_k      = !sts.hit && !sts.k_zero;
			end
			S_OPEN: begin
				cmd.open   = !sts.full;
				cmd.mul    = !sts.full;
				cmd.set_st = sts.full;
				cmd.st     = ST_OOM;
			end
			S_FRD: cmd.rd = 1'b1;
			S_FCHK: begin
				cmd.free_commit = sts.bit_set;
				cmd.set_st      = !sts.bit_set;
				cmd.st          = ST_DOUBLE;
			end
			S_DONE: cmd.finish = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* rtl/sba_dp.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator datapath
// Registers, bitmap memory, free counts, divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sba_dp
	import sba_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [A_W-1:0] cfg_data,
	input  logic           in_kind,
	input  logic [A_W-1:0] in_address,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_status,
	output logic [A_W-1:0] out_address,
	input  cmd_t           cmd,
	output sts_t           sts
);

	logic [Q_W-1:0]         quant_q;
	logic [A_W-1:0]         base_q;
	logic [Q_W-1:0]         q_eff;
	logic                   kind_q;
	logic [A_W-1:0]         off_q;
	logic [A_W-1:0]         in_off;
	logic [K_W-1:0]         k_q;
	logic [IDX_W-1:0]       idx_q;
	logic [NOBJ_W-1:0]      nobj_q;
	logic [NOBJ_W-1:0]      nobj_d;
	logic [OPN_W-1:0]       opened_q;
	logic [OPN_W-1:0]       k_init;
	logic [CNT_W-1:0]       cnt_q [MAX_CHUNKS];
	logic [MAX_OBJECTS-1:0] bits_mem [MAX_CHUNKS];
	logic [MAX_OBJECTS-1:0] row_q;
	logic [MAX_OBJECTS-1:0] vmask;
	logic [MAX_OBJECTS-1:0] free_vec;
	logic [IDX_W-1:0]       idx_hit;
	logic [PROD_W-1:0]      prod_q;
	status_t                res_st_q;
	logic                   out_valid_q;
	logic [1:0]             out_status_q;
	logic [A_W-1:0]         out_addr_q;
	logic [A_W-1:0]         obj_addr;
	logic [DVD_W-1:0]       dividend;
	logic                   div_done;
	logic [DVD_W-1:0]       quo;
	logic [Q_W-1:0]         rem;
	logic [CHK_W-1:0]       end_off;
	logic                   mem_we;
	logic [K_W-1:0]         mem_waddr;
	logic [MAX_OBJECTS-1:0] mem_wdata;

	always_comb begin
		priority if (quant_q < Q_W'(QMIN)) q_eff = Q_W'(QMIN);
		else if (quant_q > Q_W'(CHUNK_BYTES)) q_eff = Q_W'(CHUNK_BYTES);
		else q_eff = quant_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_q <= Q_W'(64);
			base_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_QUANTUM: quant_q <= cfg_data[Q_W-1:0];
				REG_BASE:    base_q  <= cfg_data;
				default:     base_q  <= base_q;
			endcase
		end
	end

	assign in_off   = in_address - base_q;
	assign dividend = (in_kind == KIND_FREE) ? {1'b0, in_off[CB_W-1:0]}
	                                         : DVD_W'(CHUNK_BYTES);

	sba_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.load),
		.dividend  (dividend),
		.divisor   (q_eff),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign nobj_d  = (quo > DVD_W'(MAX_OBJECTS)) ? NOBJ_W'(MAX_OBJECTS) : quo[NOBJ_W-1:0];
	assign k_init  = opened_q - OPN_W'(1);
	assign end_off = CHK_W'(off_q[CB_W-1:0]) - CHK_W'(rem) + CHK_W'(q_eff);

	always_comb begin
		for (int i = 0; i < MAX_OBJECTS; i++) begin
			vmask[i] = NOBJ_W'(i) < nobj_q;
		end
		free_vec = ~row_q & vmask;
		idx_hit  = '0;
		for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
			if (free_vec[i]) idx_hit = IDX_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			off_q  <= in_off;
		end
		if (cmd.alloc_init) begin
			k_q    <= k_init[K_W-1:0];
			nobj_q <= nobj_d;
		end
		if (cmd.free_init) begin
			k_q   <= off_q[CB_W +: K_W];
			idx_q <= quo[IDX_W-1:0];
		end
		if (cmd.dec_k) k_q <= k_q - K_W'(1);
		if (cmd.alloc_take) idx_q <= idx_hit;
		if (cmd.open) begin
			k_q   <= opened_q[K_W-1:0];
			idx_q <= '0;
		end
		if (cmd.mul) prod_q <= PROD_W'(cmd.open ? '0 : (cmd.alloc_take ? idx_hit : idx_q))
		                       * PROD_W'(q_eff);
		if (cmd.load) res_st_q <= ST_OK;
		else if (cmd.set_st) res_st_q <= cmd.st;
	end

	assign mem_we    = cmd.alloc_take || cmd.open || cmd.free_commit;
	assign mem_waddr = cmd.open ? opened_q[K_W-1:0] : k_q;

	always_comb begin
		priority if (cmd.open) mem_wdata = MAX_OBJECTS'(1);
		else if (cmd.alloc_take) mem_wdata = row_q | (MAX_OBJECTS'(1) << idx_hit);
		else mem_wdata = row_q & ~(MAX_OBJECTS'(1) << idx_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) bits_mem[mem_waddr] <= mem_wdata;
		if (cmd.rd) row_q <= bits_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opened_q <= '0;
			for (int c = 0; c < MAX_CHUNKS; c++) cnt_q[c] <= '0;
		end else begin
			if (cmd.open) begin
				opened_q <= opened_q + OPN_W'(1);
				cnt_q[opened_q[K_W-1:0]] <= CNT_W'(nobj_q - NOBJ_W'(1));
			end
			if (cmd.alloc_take) cnt_q[k_q] <= cnt_q[k_q] - CNT_W'(1);
			if (cmd.free_commit && cnt_q[k_q] != CNT_MAX) cnt_q[k_q] <= cnt_q[k_q] + CNT_W'(1);
		end
	end

	assign obj_addr = base_q + (A_W'(k_q) << CB_W) + A_W'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= res_st_q;
			out_addr_q   <= (res_st_q == ST_OK && kind_q == KIND_ALLOC) ? obj_addr : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_address = out_addr_q;

	assign sts.div_done    = div_done;
	assign sts.kind        = kind_q;
	assign sts.opened_zero = opened_q == '0;
	assign sts.k_zero      = k_q == '0;
	assign sts.hit         = cnt_q[k_q] != '0 && |free_vec;
	assign sts.full        = opened_q == OPN_W'(MAX_CHUNKS);
	assign sts.free_bad    = off_q[A_W-1:CB_W] >= (A_W - CB_W)'(opened_q)
	                         || end_off > CHK_W'(CHUNK_BYTES);
	assign sts.bit_set     = row_q[idx_q];
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

/* rtl/slab_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator
// Hands out and takes back fixed-size objects from bitmap-tracked chunks.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tuser: kind; tdata: address
// m_axis    out        tuser: status; tdata: object_address
// cfg       in         cfg_index 0 quantum, 1 base_address
//
// A word first passes through the divider, which retires one quotient bit per cycle.
// An allocate then reads and checks chunks in turn and opens a chunk if none has room;
// a free reads and checks one bitmap row unless it is bad. The next word is accepted only
// once the current one is done. After reset all chunks are closed and no clearing pass is
// needed. A result waits in the output register while the next word is accepted, and a new
// result stalls in the done state while that register still holds an unread word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_bitmap_allocator
	import sba_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [A_W-1:0] cfg_data,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [A_W-1:0] s_axis_tdata,   // address
	input  logic           s_axis_tuser,   // kind
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [A_W-1:0] m_axis_tdata,   // object_address
	output logic [1:0]     m_axis_tuser    // status
);

	cmd_t cmd;
	sts_t sts;

	sba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_kind     (s_axis_tuser),
		.in_address  (s_axis_tdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (m_axis_tuser),
		.out_address (m_axis_tdata),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

/* rtl/sba_checker.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slab_bitmap_allocator_macros.svh"

module sba_checker
	import sba_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	input logic           cfg_we,
	input logic           cfg_index,
	input logic [A_W-1:0] cfg_data,
	input logic           s_axis_tvalid,
	input logic           s_axis_tready,
	input logic [A_W-1:0] s_axis_tdata,
	input logic           s_axis_tuser,
	input logic           m_axis_tvalid,
	input logic           m_axis_tready,
	input logic [A_W-1:0] m_axis_tdata,
	input logic [1:0]     m_axis_tuser
);

	`SBA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled result word changed.")
	`SBA_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0, "Failed request carries an address.")
	`SBA_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "Second word accepted while busy.")
	`SBA_ASSERT_NXT(a_no_early, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "Result appeared the cycle after accept.")

endmodule

bind slab_bitmap_allocator sba_checker u_sba_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Slab bitmap allocator testbench
// Drives allocate and free words with random gaps and output stalls, predicts
// each result from a bit-level model of the chunk bitmaps, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import sba_pkg::*;

	typedef struct packed {
		kind_t          kind;
		logic [A_W-1:0] address;
	} request_t;

	typedef struct packed {
		status_t        status;
		logic [A_W-1:0] object_address;
	} reply_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic           cfg_index = 1'b0;
	logic [A_W-1:0] cfg_data = '0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	logic [A_W-1:0] s_axis_tdata = '0;
	logic           s_axis_tuser = 1'b0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	logic [A_W-1:0] m_axis_tdata;
	logic [1:0]     m_axis_tuser;

	slab_bitmap_allocator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Prediction state.
	logic [MAX_OBJECTS-1:0] used_bits [MAX_CHUNKS];
	logic [CNT_W-1:0]       free_left [MAX_CHUNKS];
	int unsigned            opened;
	logic [Q_W-1:0]         quantum_reg;
	logic [A_W-1:0]         base_reg;

	request_t    pending_words [$];
	reply_t      expected_replies [$];
	logic [A_W-1:0] live_objects [$];
	int          errors = 0;
	longint      cycles = 0;
	bit          hold_send = 1'b0;
	int          send_gap = 0;
	int          recv_gap = 0;

	function automatic reply_t allocate_or_free(request_t req);
		reply_t r;
		int unsigned q, nobj, k, idx;
		logic [A_W-1:0] off;
		bit found;
		r.status = ST_OK;
		r.object_address = '0;
		q = quantum_reg;
		if (q < QMIN) q = QMIN;
		if (q > CHUNK_BYTES) q = CHUNK_BYTES;
		nobj = CHUNK_BYTES / q;
		if (nobj > MAX_OBJECTS) nobj = MAX_OBJECTS;
		if (req.kind == KIND_ALLOC) begin
			found = 1'b0;
			k = opened;
			idx = 0;
			while (k > 0 && !found) begin
				k--;
				if (free_left[k] != 0) begin
					for (int i = 0; i < nobj; i++) begin
						if (!used_bits[k][i]) begin
							idx = i;
							found = 1'b1;
							break;
						end
					end
				end
			end
			if (found) begin
				used_bits[k][idx] = 1'b1;
				free_left[k]--;
				r.object_address = base_reg + k * CHUNK_BYTES + idx * q;
			end else if (opened < MAX_CHUNKS) begin
				k = opened;
				used_bits[k] = '0;
				used_bits[k][0] = 1'b1;
				free_left[k] = CNT_W'(nobj - 1);
				opened++;
				r.object_address = base_reg + k * CHUNK_BYTES;
			end else begin
				r.status = ST_OOM;
			end
		end else begin
			off = req.address - base_reg;
			k = off / CHUNK_BYTES;
			idx = (off % CHUNK_BYTES) / q;
			if (k >= opened || idx >= nobj) r.status = ST_BAD;
			else if (!used_bits[k][idx]) r.status = ST_DOUBLE;
			else begin
				used_bits[k][idx] = 1'b0;
				if (free_left[k] != CNT_MAX) free_left[k]++;
			end
		end
		return r;
	endfunction

	// Driver.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_replies.push_back(allocate_or_free({kind_t'(s_axis_tuser), s_axis_tdata}));
			s_axis_tvalid <= 1'b0;
			send_gap <= $urandom_range(0, 12);
		end else if (!s_axis_tvalid && !hold_send && pending_words.size() != 0) begin
			if (send_gap > 0) send_gap <= send_gap - 1;
			else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= pending_words[0].kind;
				s_axis_tdata <= pending_words[0].address;
				void'(pending_words.pop_front());
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		reply_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected word status %0d addr %h", $time, m_axis_tuser,
					m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_replies.pop_front();
				if (m_axis_tuser != exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
						m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata != exp_r.object_address) begin
					$display("%0t: address expected %h actual %h", $time,
						exp_r.object_address, m_axis_tdata);
					errors++;
				end
				if (exp_r.status == ST_OK && exp_r.object_address != '0)
					live_objects.push_back(exp_r.object_address);
			end
			m_axis_tready <= 1'b0;
			recv_gap <= $urandom_range(0, 12);
		end else if (!m_axis_tready) begin
			if (recv_gap > 0) recv_gap <= recv_gap - 1;
			else m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic add_word(kind_t k, logic [A_W-1:0] a);
		pending_words.push_back({k, a});
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !s_axis_tvalid);
		wait (expected_replies.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [A_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_QUANTUM) quantum_reg = v[Q_W-1:0];
		else base_reg = v;
	endtask

	task automatic random_phase(int n);
		logic [A_W-1:0] a;
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) add_word(KIND_ALLOC, $urandom);
			else if (sel < 85 && live_objects.size() != 0) begin
				sel = $urandom_range(0, live_objects.size() - 1);
				a = live_objects[sel];
				live_objects.delete(sel);
				add_word(KIND_FREE, a);
			end else if (sel < 92) add_word(KIND_FREE, base_reg + $urandom_range(0, 20 * 4096));
			else add_word(KIND_FREE, $urandom);
			// Keep the live list roughly in step with accepted results.
			if (pending_words.size() > 8) wait (pending_words.size() < 4);
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			used_bits[i] = '0;
			free_left[i] = '0;
		end
		opened = 0;
		quantum_reg = 64;
		base_reg = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: extremes, double free, bad address, slack.
		add_word(KIND_FREE, 32'h0);
		add_word(KIND_ALLOC, 32'hFFFF_FFFF);
		add_word(KIND_ALLOC, 32'h0);
		add_word(KIND_FREE, 32'h40);
		add_word(KIND_FREE, 32'h40);
		add_word(KIND_FREE, 32'h0);
		add_word(KIND_FREE, 32'hFFFF_FFFF);
		add_word(KIND_FREE, 32'h1000);
		drain();
		write_reg(REG_QUANTUM, 32'd1);
		write_reg(REG_BASE, 32'hFFFF_F000);
		add_word(KIND_ALLOC, '0);
		add_word(KIND_ALLOC, '0);
		add_word(KIND_FREE, 32'hFFFF_F000);
		add_word(KIND_FREE, 32'h0000_0040);
		drain();
		write_reg(REG_QUANTUM, 32'h1FFF);
		for (int i = 0; i < 18; i++) add_word(KIND_ALLOC, '0);
		add_word(KIND_FREE, 32'hFFFF_F800);
		drain();
		write_reg(REG_QUANTUM, 32'd3000);
		add_word(KIND_FREE, 32'h0000_0BB8);
		add_word(KIND_FREE, 32'h0000_0000);
		drain();
		hold_send = 1'b1;
		repeat (30) @(posedge clk);
		hold_send = 1'b0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_reg(REG_QUANTUM, 32'd64);
				1: write_reg(REG_QUANTUM, 32'd4096);
				2: write_reg(REG_BASE, $urandom);
				3: write_reg(REG_QUANTUM, $urandom_range(64, 4096));
				4: write_reg(REG_BASE, 32'h0);
				default: write_reg(REG_QUANTUM, $urandom_range(0, 8191));
			endcase
			random_phase(250);
			drain();
		end
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule
